/* src/pm_pkg.sv */
// Package for the pattern metronome: item kinds, controller states,
// command/status structs and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package pm_pkg;

    // Fixed field widths of the stream items
    localparam int ADDR_W     = 6;
    localparam int TICKS_W    = 16;
    localparam int LEN_IN_W   = 7;
    localparam int BEAT_W     = 6;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;

    // Item kinds, carried in s_tuser
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_RUN    = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_COMMIT = 2'd3
    } kind_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRAP,
        ST_MOD,
        ST_READ,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;      // latch the accepted item
        logic run_off;      // stop the count
        logic write_entry;  // write shadow entry
        logic commit;       // commit shadow bank
        logic tick_step;    // decrement countdown, maybe swap banks
        logic mod_start;    // start (position + 1) mod length
        logic mod_apply;    // take the new position
        logic mem_read;     // read the interval of the current entry
        logic emit;         // reload countdown and load the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  run_on;
        logic  running;
        logic  tick_zero;   // countdown reaches zero on this tick
        logic  mod_done;
        logic  out_free;    // output register can take a new item
    } status_t;

endpackage

/* src/pm_mod.sv */
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps

module pm_mod #(
    parameter int WIDTH = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH:0]   trial;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, dvd_reg[WIDTH-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = WIDTH'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = WIDTH'(trial);
            end
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* src/pm_ctrl.sv */
// Controller FSM of the pattern metronome: sequences one item at a time.
// Depends on pm_pkg.
`timescale 1ns / 1ps

module pm_ctrl
    import pm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.kind)
                    KIND_TICK: begin
                        if (status.running && status.tick_zero) begin
                            state_next = ST_WRAP;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_RUN: begin
                        state_next = status.run_on ? ST_READ : ST_IDLE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WRAP: begin
                state_next = ST_MOD;
            end
            ST_MOD: begin
                if (status.mod_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECODE: begin
                case (status.kind)
                    KIND_TICK:   cmd.tick_step   = status.running;
                    KIND_RUN:    cmd.run_off     = !status.run_on;
                    KIND_WRITE:  cmd.write_entry = 1'b1;
                    KIND_COMMIT: cmd.commit      = 1'b1;
                    default:     cmd.commit      = 1'b0;
                endcase
            end
            ST_WRAP: begin
                cmd.mod_start = 1'b1;
            end
            ST_MOD: begin
                cmd.mod_apply = status.mod_done;
            end
            ST_READ: begin
                cmd.mem_read = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/pm_dp.sv */
// Datapath of the pattern metronome: interval memory, banks, countdown,
// position, modulo unit and output register. Depends on pm_pkg and pm_mod.
`timescale 1ns / 1ps

module pm_dp
    import pm_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int TICK_BITS   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [1:0]          in_kind,
    input  logic                in_run_on,
    input  logic [ADDR_W-1:0]   in_entry_addr,
    input  logic [TICKS_W-1:0]  in_entry_ticks,
    input  logic [LEN_IN_W-1:0] in_pattern_length,
    input  logic                cfg_we,
    input  logic                cfg_sync_mode,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BEAT_W-1:0]   out_beat_index,
    output logic                out_cycle_end,
    output logic                out_run_beat
);

    localparam int POS_W = $clog2(MAX_ENTRIES);
    localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
    localparam int DEPTH = 2 * MAX_ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [32:0] CAP = (33'd1 << TICK_BITS) - 33'd1;

    // Captured item
    kind_t               kind_reg;
    logic                run_on_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [TICKS_W-1:0]  ticks_reg;
    logic [LEN_IN_W-1:0] plen_reg;

    // Pattern and count state
    logic [TICKS_W-1:0]  interval_mem [DEPTH];
    logic [TICKS_W-1:0]  rd_data_reg;
    logic [LEN_W-1:0]    bank_len_reg [2];
    logic                active_bank_reg;
    logic                commit_pending_reg;
    logic                sync_mode_reg;
    logic                running_reg;
    logic [POS_W-1:0]    position_reg;
    logic [TICK_BITS-1:0] countdown_reg;

    // Output register
    logic                out_valid_reg;
    logic [BEAT_W-1:0]   beat_index_reg;
    logic                cycle_end_reg;
    logic                run_beat_reg;

    logic                 shadow;
    logic [LEN_W-1:0]     act_len;
    logic [LEN_W-1:0]     pos_ext;
    logic                 at_last;
    logic                 bank_swap;
    logic [POS_W-1:0]     rd_idx;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;
    logic [LEN_W-1:0]     commit_len;
    logic [TICK_BITS-1:0] reload_val;
    logic                 mod_done;
    logic [LEN_W-1:0]     mod_rem;

    assign shadow  = ~active_bank_reg;
    assign act_len = bank_len_reg[active_bank_reg];
    assign pos_ext = LEN_W'(position_reg);
    assign at_last = (act_len != '0) && (pos_ext == act_len - LEN_W'(1));
    assign bank_swap = at_last && sync_mode_reg && commit_pending_reg;

    // Entry index: out-of-range positions fall back to entry 0
    assign rd_idx  = (pos_ext < act_len) ? position_reg : '0;
    assign rd_addr = AW'(active_bank_reg ? MAX_ENTRIES : 0) + AW'(rd_idx);

    // Shadow write, zero intervals and out-of-bank addresses dropped
    assign wr_en   = cmd.write_entry && (ticks_reg != '0)
                     && (32'(addr_reg) < MAX_ENTRIES);
    assign wr_addr = AW'(shadow ? MAX_ENTRIES : 0) + AW'(addr_reg);

    // Commit length saturates at the bank size
    assign commit_len = (32'(plen_reg) > MAX_ENTRIES) ? LEN_W'(MAX_ENTRIES)
                                                      : LEN_W'(plen_reg);

    // Reload value: zero without a pattern, saturated to the counter width
    always_comb begin
        if (act_len == '0) begin
            reload_val = '0;
        end else if (33'(rd_data_reg) > CAP) begin
            reload_val = TICK_BITS'(CAP);
        end else begin
            reload_val = TICK_BITS'(rd_data_reg);
        end
    end

    // (position + 1) mod length
    pm_mod #(
        .WIDTH(LEN_W)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mod_start),
        .dividend (pos_ext + LEN_W'(1)),
        .divisor  (act_len),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    // Interval memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            interval_mem[wr_addr] <= ticks_reg;
        end
        if (cmd.mem_read) begin
            rd_data_reg <= interval_mem[rd_addr];
        end
    end

    // Item capture and output payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= kind_t'(in_kind);
            run_on_reg <= in_run_on;
            addr_reg   <= in_entry_addr;
            ticks_reg  <= in_entry_ticks;
            plen_reg   <= in_pattern_length;
        end
        if (cmd.emit) begin
            beat_index_reg <= BEAT_W'(position_reg);
            run_beat_reg   <= (kind_reg == KIND_RUN);
            cycle_end_reg  <= (kind_reg != KIND_RUN) && (position_reg == '0);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_len_reg[0]    <= '0;
            bank_len_reg[1]    <= '0;
            active_bank_reg    <= 1'b0;
            commit_pending_reg <= 1'b0;
            sync_mode_reg      <= 1'b0;
            running_reg        <= 1'b0;
            position_reg       <= '0;
            countdown_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                sync_mode_reg <= cfg_sync_mode;
            end
            if (cmd.run_off) begin
                running_reg <= 1'b0;
            end
            if (cmd.tick_step) begin
                if (countdown_reg != '0) begin
                    countdown_reg <= countdown_reg - TICK_BITS'(1);
                end
                if (status.tick_zero && bank_swap) begin
                    commit_pending_reg <= 1'b0;
                    active_bank_reg    <= shadow;
                end
            end
            if (cmd.commit && (plen_reg != '0)) begin
                bank_len_reg[shadow] <= commit_len;
                if (sync_mode_reg && (act_len != '0)) begin
                    commit_pending_reg <= 1'b1;
                end else begin
                    active_bank_reg    <= shadow;
                    commit_pending_reg <= 1'b0;
                end
            end
            if (cmd.mod_apply && (act_len != '0)) begin
                position_reg <= POS_W'(mod_rem);
            end
            if (cmd.emit) begin
                countdown_reg <= reload_val;
                running_reg   <= (reload_val != '0);
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.kind      = kind_reg;
    assign status.run_on    = run_on_reg;
    assign status.running   = running_reg;
    assign status.tick_zero = (countdown_reg <= TICK_BITS'(1));
    assign status.mod_done  = mod_done;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_beat_index = beat_index_reg;
    assign out_cycle_end  = cycle_end_reg;
    assign out_run_beat   = run_beat_reg;

endmodule

/* src/pattern_metronome_top.sv */
// Pattern metronome: steps through a table of tick intervals and emits a
// beat each time a countdown expires or the count is started. Items are
// processed one at a time. A tick that does not end an interval, a run-off,
// an entry write and a commit are each handled in the decode state alone; a
// run-on reads the interval memory and then waits on the output register; a
// tick that ends an interval first runs the bit-serial remainder unit that
// wraps the position, in LEN_W = clog2(MAX_ENTRIES + 1) steps, then reads the
// interval memory and waits on the output register. A finished beat sits in
// the output register so the next item can be accepted while it waits.
// Pattern writes go to the shadow bank; while a pattern is active, sync_mode
// defers commits to the end of the current pattern cycle. Entries of the
// interval memory read before ever being written return unspecified data.
// Depends on pm_pkg, pm_ctrl, pm_dp and pm_mod.
`timescale 1ns / 1ps

module pattern_metronome_top
    import pm_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int TICK_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] run_on, [6:1] entry_addr, [22:7] entry_ticks,
    // [29:23] pattern_length, [31:30] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]           s_tuser,
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [5:0] beat_index, [7:6] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // cycle_end
    output logic                 m_tlast,
    // [0] run_beat: beat caused by run-on
    output logic [0:0]           m_tuser,
    // sync_mode register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_data
);

    cmd_t                cmd;
    status_t             status;
    logic [BEAT_W-1:0]   beat_index;
    logic                run_beat;

    assign cfg_ready = 1'b1;

    pm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    pm_dp #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .TICK_BITS  (TICK_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .in_kind          (s_tuser),
        .in_run_on        (s_tdata[0]),
        .in_entry_addr    (s_tdata[6:1]),
        .in_entry_ticks   (s_tdata[22:7]),
        .in_pattern_length(s_tdata[29:23]),
        .cfg_we           (cfg_valid),
        .cfg_sync_mode    (cfg_data[0]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_beat_index   (beat_index),
        .out_cycle_end    (m_tlast),
        .out_run_beat     (run_beat)
    );

    // Pack the result
    assign m_tdata    = M_TDATA_W'(beat_index);
    assign m_tuser[0] = run_beat;

endmodule

/* sim/pattern_metronome_top_tb.sv */
// Self-checking testbench for pattern_metronome_top: drives tick, run, entry
// write and commit items with random stalls on both streams, predicts each
// beat and compares it. Depends on pm_pkg and the pattern_metronome RTL.
`timescale 1ns / 1ps

module pattern_metronome_top_tb;
    import pm_pkg::*;

    localparam int     N_ENTRIES     = 64;
    localparam int     SETTLE_CYCLES = 24;   // longest item plus output slack
    localparam int     DRAIN_LIMIT   = 4000;
    localparam int     RANDOM_ITEMS  = 800;
    localparam logic   SYNC_OFF      = 1'b0;
    localparam logic   SYNC_ON       = 1'b1;

    // One beat as it leaves the block
    typedef struct packed {
        logic [BEAT_W-1:0] idx;
        logic              wrap;
        logic              start;
    } beat_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]           s_tuser   = KIND_TICK;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [0:0]           cfg_data  = '0;

    // Metronome state as the testbench sees it
    logic [TICKS_W-1:0]  iv_table [0:1][0:N_ENTRIES-1];
    bit                  iv_valid [0:1][0:N_ENTRIES-1];
    logic [LEN_IN_W-1:0] bank_len [0:1];
    logic                live_bank;
    logic                swap_waiting;
    logic                counting;
    logic [BEAT_W-1:0]   pos;
    logic [TICKS_W-1:0]  remaining;
    logic                sync_on;

    beat_t beats_due[$];
    bit    calm = 1'b0;
    int    errors = 0;
    int    live_items = 0;
    int    beats_seen = 0;
    int    wraps_seen = 0;
    int    sync_writes = 0;

    pattern_metronome_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Result stall: tready low with a chance of 13 in 100, none while calm
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 13);
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------
    function automatic void clear_metronome();
        for (int b = 0; b < 2; b++) begin
            bank_len[b] = '0;
            for (int i = 0; i < N_ENTRIES; i++) begin
                iv_table[b][i] = '0;
                iv_valid[b][i] = 1'b0;
            end
        end
        live_bank    = 1'b0;
        swap_waiting = 1'b0;
        counting     = 1'b0;
        pos          = '0;
        remaining    = '0;
        sync_on      = SYNC_OFF;
    endfunction

    // Load the countdown from the current entry; an index past the length
    // falls back to entry 0, no pattern or a zero interval stops the count
    function automatic void reload_count();
        logic [LEN_IN_W-1:0] n;
        logic [BEAT_W-1:0]   idx;
        n = bank_len[live_bank];
        if (n == 0) begin
            remaining = '0;
        end else begin
            idx = ({1'b0, pos} < n) ? pos : '0;
            remaining = iv_table[live_bank][idx];
        end
        counting = (remaining != 0);
    endfunction

    // Apply one accepted item; queues the beat it causes. Returns 1 unless
    // the block simply ignores the item.
    function automatic bit advance_metronome(kind_t k, logic on, logic [ADDR_W-1:0] addr,
                                             logic [TICKS_W-1:0] tk,
                                             logic [LEN_IN_W-1:0] len);
        logic                shadow;
        logic [LEN_IN_W-1:0] n;
        beat_t               b;
        shadow = ~live_bank;
        case (k)
            KIND_TICK: begin
                if (!counting)
                    return 1'b0;
                if (remaining != 0)
                    remaining = remaining - 1'b1;
                if (remaining != 0)
                    return 1'b1;
                n = bank_len[live_bank];
                // deferred commit lands on the tick that leaves the last entry
                if (n != 0 && {1'b0, pos} == n - 1'b1 && sync_on && swap_waiting) begin
                    swap_waiting = 1'b0;
                    live_bank    = shadow;
                    n            = bank_len[live_bank];
                end
                if (n != 0)
                    pos = BEAT_W'((int'(pos) + 1) % int'(n));
                reload_count();
                b.idx   = pos;
                b.wrap  = (pos == 0);
                b.start = 1'b0;
                beats_due.push_back(b);
                return 1'b1;
            end
            KIND_RUN: begin
                if (on) begin
                    reload_count();
                    b.idx   = pos;
                    b.wrap  = 1'b0;
                    b.start = 1'b1;
                    beats_due.push_back(b);
                end else begin
                    counting = 1'b0;
                end
                return 1'b1;
            end
            KIND_WRITE: begin
                if (tk == 0)
                    return 1'b0;
                iv_table[shadow][addr] = tk;
                iv_valid[shadow][addr] = 1'b1;
                return 1'b1;
            end
            default: begin
                if (len == 0)
                    return 1'b0;
                bank_len[shadow] = (len > N_ENTRIES) ? LEN_IN_W'(N_ENTRIES) : len;
                if (sync_on && bank_len[live_bank] != 0) begin
                    swap_waiting = 1'b1;
                end else begin
                    live_bank    = shadow;
                    swap_waiting = 1'b0;
                end
                return 1'b1;
            end
        endcase
    endfunction

    //------------------------------------------------------------------
    // Result checking
    //------------------------------------------------------------------
    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (m_tlast)
                wraps_seen++;
            if (beats_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected beat idx=%0d cycle_end=%0b run_beat=%0b",
                             $realtime, m_tdata[BEAT_W-1:0], m_tlast, m_tuser[0]);
            end else begin
                want = beats_due.pop_front();
                if (m_tdata[BEAT_W-1:0] !== want.idx || m_tlast !== want.wrap ||
                    m_tuser[0] !== want.start) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: beat mismatch idx %0d/%0d cycle_end %0b/%0b %s %0b/%0b",
                                 $realtime, m_tdata[BEAT_W-1:0], want.idx, m_tlast,
                                 want.wrap, "run_beat", m_tuser[0], want.start);
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus primitives
    //------------------------------------------------------------------
    // Present one item, with random idle cycles ahead of it, and wait until
    // the block takes it
    task automatic send_item(kind_t k, logic on, logic [ADDR_W-1:0] addr,
                             logic [TICKS_W-1:0] tk, logic [LEN_IN_W-1:0] len);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {2'b00, len, tk, addr, on};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (advance_metronome(k, on, addr, tk, len))
            live_items++;
    endtask

    // Unused fields carry random values
    task automatic send_tick();
        send_item(KIND_TICK, 1'($urandom), ADDR_W'($urandom), TICKS_W'($urandom),
                  LEN_IN_W'($urandom));
    endtask

    task automatic send_run(logic on);
        send_item(KIND_RUN, on, ADDR_W'($urandom), TICKS_W'($urandom), LEN_IN_W'($urandom));
    endtask

    task automatic send_write(logic [ADDR_W-1:0] addr, logic [TICKS_W-1:0] tk);
        send_item(KIND_WRITE, 1'($urandom), addr, tk, LEN_IN_W'($urandom));
    endtask

    task automatic send_commit(logic [LEN_IN_W-1:0] len);
        send_item(KIND_COMMIT, 1'($urandom), ADDR_W'($urandom), TICKS_W'($urandom), len);
    endtask

    task automatic bus_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // sync_mode is written only with the block drained and settled
    task automatic set_sync(logic v);
        bus_idle();
        while (beats_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sync_on = v;
        sync_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly short intervals so beats come often
    function automatic logic [TICKS_W-1:0] pick_ticks();
        if ($urandom_range(4) != 0)
            return TICKS_W'($urandom_range(1, 4));
        return TICKS_W'($urandom_range(5, 16));
    endfunction

    // Fill the shadow bank up to the new length, then commit it. Every entry
    // below the length that was never written is written before the commit, so
    // no read ever hits a never-written entry.
    task automatic load_pattern(bit full);
        logic [LEN_IN_W-1:0] len;
        int                  lim;
        logic                sh;
        len = full ? LEN_IN_W'($urandom_range(N_ENTRIES, 127))
                   : LEN_IN_W'($urandom_range(1, 8));
        lim = (len > N_ENTRIES) ? N_ENTRIES : int'(len);
        sh  = ~live_bank;
        for (int i = 0; i < lim; i++) begin
            if (full || !iv_valid[sh][i] || $urandom_range(2) == 0)
                send_write(ADDR_W'(i), pick_ticks());
        end
        send_commit(len);
        if ($urandom_range(1))
            send_run(1'b1);
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    // Out of reset: nothing to count, a run-on still beats at index 0
    task automatic test_reset_state();
        send_tick();
        send_run(1'b0);
        send_run(1'b1);
        send_tick();
        send_commit('0);
        send_write('0, '0);
    endtask

    // With sync_mode set but no pattern active, the first commit is at once
    task automatic test_first_commit_sync();
        set_sync(SYNC_ON);
        send_write(6'd0, 16'd1);
        send_write(6'd1, 16'd1);
        send_write(6'd2, 16'd2);
        send_commit(7'd3);
        send_run(1'b1);
        repeat (4) send_tick();
        send_run(1'b1);     // restart while running
    endtask

    // Commit waits for the tick that leaves the last entry
    task automatic test_deferred_commit();
        send_write(6'd0, 16'd1);
        send_write(6'd1, 16'd1);
        send_commit(7'd2);
        repeat (6) send_tick();
    endtask

    // Immediate commit of a one-entry pattern, field extremes, stop
    task automatic test_immediate_commit();
        set_sync(SYNC_OFF);
        send_write(6'd63, 16'hFFFF);
        send_write(6'd33, 16'h5555);
        send_write(6'd0, 16'd0);
        send_commit(7'd1);
        repeat (2) send_tick();
        send_run(1'b0);
        send_tick();
    endtask

    task automatic test_random_traffic(int target);
        int unsigned pick;
        int          n;
        int          next_toggle;
        int          start_count;
        start_count = live_items;
        next_toggle = live_items + 130;
        while (live_items - start_count < target) begin
            if (live_items >= next_toggle) begin
                set_sync(~sync_on);
                next_toggle = live_items + 130;
            end
            // one long stretch with no stalls on either side
            calm = (live_items - start_count >= target / 2) &&
                   (live_items - start_count < target / 2 + 100);
            pick = $urandom_range(99);
            n    = $urandom_range(3, 20);
            if (pick < 40) begin
                if (!counting && bank_len[live_bank] != 0 && $urandom_range(3) != 0)
                    send_run(1'b1);
                repeat (n) send_tick();
            end else if (pick < 55) begin
                load_pattern(1'b0);
            end else if (pick < 58) begin
                load_pattern(1'b1);
            end else if (pick < 70) begin
                send_run($urandom_range(4) != 0);
            end else if (pick < 80) begin
                case ($urandom_range(2))
                    0: send_write(ADDR_W'($urandom), '0);
                    1: send_commit('0);
                    default: send_write(ADDR_W'($urandom), pick_ticks());
                endcase
            end else begin
                repeat (n) begin
                    if ($urandom_range(9) == 0)
                        send_run(1'b1);
                    else
                        send_tick();
                end
            end
        end
        calm = 1'b0;
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin
        clear_metronome();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_first_commit_sync();
        test_deferred_commit();
        test_immediate_commit();
        test_random_traffic(RANDOM_ITEMS);

        bus_idle();
        for (int k = 0; k < DRAIN_LIMIT && beats_due.size() != 0; k++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (beats_due.size() != 0) begin
            errors += beats_due.size();
            $display("%0d expected beats never arrived", beats_due.size());
        end

        $display("Covered %0d live items, %0d beats checked (%0d at cycle end),",
                 live_items, beats_seen, wraps_seen);
        $display("%0d sync_mode writes, both streams stalled at random.", sync_writes);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout: %0d beats still expected", beats_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
